FILE: rtl/pns_pkg.sv
// pns_pkg: shared constants, codes and interface structs for the pattern note sequencer
// no dependencies; used by every rtl file of the block
`default_nettype none

package pns_pkg;

    localparam int PATTERNS_DEF = 2;
    localparam int NOTES_DEF    = 5;

    localparam int FPB_W   = 20;
    localparam int BEAT_W  = 16;
    localparam int PROD_W  = BEAT_W + FPB_W;
    localparam int FRAME_W = 28;
    localparam int POS_W   = 28;
    localparam int PITCH_W = 7;
    localparam int BASE_W  = 8;
    localparam int PLEN_W  = 8;
    localparam int OCT_W   = 4;

    localparam logic [FPB_W-1:0]   FPB_RESET     = 20'd22050;
    localparam logic [BASE_W-1:0]  SEMIS_PER_OCT = 8'd12;
    localparam logic [PITCH_W-1:0] VEL_ON        = 7'd100;
    localparam logic [PITCH_W-1:0] VEL_OFF       = 7'd0;
    localparam logic [PITCH_W-1:0] NOTE_MAX      = 7'd127;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_NOTE = 2'd1,
        ACT_PAT  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CFG_FPB = 1'b0,
        CFG_RUN = 1'b1
    } t_cfg_idx;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PAT  = 7'b0000010,
        S_MST  = 7'b0000100,
        S_MLEN = 7'b0001000,
        S_EVAL = 7'b0010000,
        S_ADV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // table load from the host side
    typedef struct packed {
        logic                note_we;
        logic                pat_we;
        logic [0:0]          pslot;
        logic [2:0]          nslot;
        logic [BEAT_W-1:0]   start;
        logic [BEAT_W-1:0]   len;
        logic [PITCH_W-1:0]  pitch;
        logic [PLEN_W-1:0]   plen;
        logic [BASE_W-1:0]   base;
    } t_host_wr;

    // play state update from the sequencer
    typedef struct packed {
        logic             pos_we;
        logic [POS_W-1:0] pos;
        logic             snd_we;
        logic             snd;
    } t_seq_upd;

endpackage

`default_nettype wire

FILE: rtl/pns_mul.sv
// pns_mul: shared registered 16x20 multiplier, used for every beat to frame conversion
// depends on pns_pkg for widths
`default_nettype none

module pns_mul (
    input  wire logic                         i_clk,
    input  wire logic [pns_pkg::BEAT_W-1:0]   i_a,
    input  wire logic [pns_pkg::FPB_W-1:0]    i_b,
    output logic      [pns_pkg::PROD_W-1:0]   o_p
);

    logic [pns_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= pns_pkg::PROD_W'(i_a) * pns_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/pns_table.sv
// pns_table: pattern and note tables plus per-pattern position and per-note sounding flags
// depends on pns_pkg for the write structs and widths
`default_nettype none

module pns_table #(
    parameter int PATTERNS          = pns_pkg::PATTERNS_DEF,
    parameter int NOTES_PER_PATTERN = pns_pkg::NOTES_DEF,
    parameter int PW                = 1,
    parameter int KW                = 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pns_pkg::t_host_wr               i_host,
    input  wire pns_pkg::t_seq_upd               i_upd,
    input  wire logic [PW-1:0]                   i_pat,
    input  wire logic [KW-1:0]                   i_k,
    output logic      [pns_pkg::PLEN_W-1:0]      o_plen,
    output logic      [pns_pkg::BASE_W-1:0]      o_pbase,
    output logic      [pns_pkg::POS_W-1:0]       o_ppos,
    output logic      [pns_pkg::BEAT_W-1:0]      o_nstart,
    output logic      [pns_pkg::BEAT_W-1:0]      o_nlen,
    output logic      [pns_pkg::PITCH_W-1:0]     o_npitch,
    output logic                                 o_nsnd
);

    localparam int SLOTS = PATTERNS * NOTES_PER_PATTERN;

    logic [pns_pkg::PLEN_W-1:0]  r_plen  [PATTERNS];
    logic [pns_pkg::BASE_W-1:0]  r_pbase [PATTERNS];
    logic [pns_pkg::POS_W-1:0]   r_ppos  [PATTERNS];
    logic [pns_pkg::BEAT_W-1:0]  r_start [SLOTS];
    logic [pns_pkg::BEAT_W-1:0]  r_len   [SLOTS];
    logic [pns_pkg::PITCH_W-1:0] r_pitch [SLOTS];
    logic [SLOTS-1:0]            r_snd;

    logic          pslot_ok;
    logic          nslot_ok;
    logic [KW-1:0] host_k;
    logic [PW-1:0] host_p;

    assign pslot_ok = int'(i_host.pslot) < PATTERNS;
    assign nslot_ok = int'(i_host.nslot) < NOTES_PER_PATTERN;
    assign host_p   = PW'(i_host.pslot);
    assign host_k   = KW'(int'(i_host.pslot) * NOTES_PER_PATTERN + int'(i_host.nslot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERNS; i++) begin
                r_plen[i]  <= '0;
                r_pbase[i] <= '0;
                r_ppos[i]  <= '0;
            end
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i] <= '0;
                r_len[i]   <= '0;
                r_pitch[i] <= '0;
            end
            r_snd <= '0;
        end else begin
            if (i_host.note_we && pslot_ok && nslot_ok) begin
                r_start[host_k] <= i_host.start;
                r_len[host_k]   <= i_host.len;
                r_pitch[host_k] <= i_host.pitch;
            end
            if (i_host.pat_we && pslot_ok) begin
                r_plen[host_p]  <= i_host.plen;
                r_pbase[host_p] <= i_host.base;
            end
            if (i_upd.pos_we) begin
                r_ppos[i_pat] <= i_upd.pos;
            end
            if (i_upd.snd_we) begin
                r_snd[i_k] <= i_upd.snd;
            end
        end
    end

    assign o_plen   = r_plen[i_pat];
    assign o_pbase  = r_pbase[i_pat];
    assign o_ppos   = r_ppos[i_pat];
    assign o_nstart = r_start[i_k];
    assign o_nlen   = r_len[i_k];
    assign o_npitch = r_pitch[i_k];
    assign o_nsnd   = r_snd[i_k];

endmodule

`default_nettype wire

FILE: rtl/pattern_note_sequencer.sv
// pattern_note_sequencer: a write item leaves busy low; a tick while running scans all patterns,
// steps each active one note by note through the one shared multiplier (loop length once per
// pattern, then each note's start and length); the last word strobes on the return to idle.
// one item at a time; results come as single-cycle strobes and cannot be stalled.
// synchronous active-low reset clears tables, positions and sounding flags and resets config to defaults
// depends on pns_pkg, pns_mul, pns_table
`default_nettype none

module pattern_note_sequencer #(
    parameter int PATTERNS          = pns_pkg::PATTERNS_DEF,
    parameter int NOTES_PER_PATTERN = pns_pkg::NOTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_action,
    input  wire logic [0:0]                    i_pattern_slot,
    input  wire logic [2:0]                    i_note_slot,
    input  wire logic [pns_pkg::BEAT_W-1:0]    i_start_beats,
    input  wire logic [pns_pkg::BEAT_W-1:0]    i_length_beats,
    input  wire logic [pns_pkg::PITCH_W-1:0]   i_pitch_offset,
    input  wire logic [pns_pkg::PLEN_W-1:0]    i_pattern_beats,
    input  wire logic [pns_pkg::OCT_W-1:0]     i_base_octave,
    input  wire logic [pns_pkg::OCT_W-1:0]     i_base_note,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [pns_pkg::FPB_W-1:0]     i_cfg_data,
    output logic                               o_strobe,
    output logic                               o_is_note_on,
    output logic      [pns_pkg::PITCH_W-1:0]   o_note_number,
    output logic      [pns_pkg::PITCH_W-1:0]   o_velocity,
    output logic                               o_last
);

    localparam int PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int NW = (NOTES_PER_PATTERN > 1) ? $clog2(NOTES_PER_PATTERN) : 1;
    localparam int KW = (PATTERNS * NOTES_PER_PATTERN > 1) ?
                        $clog2(PATTERNS * NOTES_PER_PATTERN) : 1;
    localparam logic [PW-1:0] PAT_LAST  = PW'(PATTERNS - 1);
    localparam logic [NW-1:0] NOTE_LAST = NW'(NOTES_PER_PATTERN - 1);

    localparam int FW = pns_pkg::FRAME_W;

    pns_pkg::t_state r_state, n_state;
    logic [PW-1:0]               r_pat, n_pat;
    logic [NW-1:0]               r_note, n_note;
    logic [FW-1:0]               r_loop_end, n_loop_end;
    logic [FW-1:0]               r_s, n_s;
    logic [pns_pkg::FPB_W-1:0]   r_fpb;
    logic                        r_run;
    logic                        r_pend_valid, n_pend_valid;
    logic                        r_pend_on, n_pend_on;
    logic [pns_pkg::PITCH_W-1:0] r_pend_num, n_pend_num;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_on, n_out_on;
    logic [pns_pkg::PITCH_W-1:0] r_out_num, n_out_num;
    logic                        r_out_last, n_out_last;

    logic                        accept;
    pns_pkg::t_action            act;
    pns_pkg::t_host_wr           host;
    pns_pkg::t_seq_upd           upd;
    logic [KW-1:0]               k;
    logic [pns_pkg::BEAT_W-1:0]  mul_a;
    logic [pns_pkg::PROD_W-1:0]  prod;

    logic [pns_pkg::PLEN_W-1:0]  plen;
    logic [pns_pkg::BASE_W-1:0]  pbase;
    logic [pns_pkg::POS_W-1:0]   ppos;
    logic [pns_pkg::BEAT_W-1:0]  nstart;
    logic [pns_pkg::BEAT_W-1:0]  nlen;
    logic [pns_pkg::PITCH_W-1:0] npitch;
    logic                        nsnd;

    logic [FW:0]                 e_frames;
    logic [FW:0]                 pos_ext;
    logic [FW:0]                 pos_inc;
    logic                        on_hit;
    logic                        off_hit;
    logic [pns_pkg::BASE_W:0]    pitch_sum;
    logic [pns_pkg::PITCH_W-1:0] pitch_sat;

    assign busy        = (r_state != pns_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign act         = pns_pkg::t_action'(i_action);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        host.note_we = accept && (act == pns_pkg::ACT_NOTE);
        host.pat_we  = accept && (act == pns_pkg::ACT_PAT);
        host.pslot   = i_pattern_slot;
        host.nslot   = i_note_slot;
        host.start   = i_start_beats;
        host.len     = i_length_beats;
        host.pitch   = i_pitch_offset;
        host.plen    = i_pattern_beats;
        host.base    = pns_pkg::BASE_W'(i_base_octave) * pns_pkg::SEMIS_PER_OCT
                     + pns_pkg::BASE_W'(i_base_note);
    end

    assign k = KW'(int'(r_pat) * NOTES_PER_PATTERN + int'(r_note));

    pns_table #(
        .PATTERNS          (PATTERNS),
        .NOTES_PER_PATTERN (NOTES_PER_PATTERN),
        .PW                (PW),
        .KW                (KW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_host   (host),
        .i_upd    (upd),
        .i_pat    (r_pat),
        .i_k      (k),
        .o_plen   (plen),
        .o_pbase  (pbase),
        .o_ppos   (ppos),
        .o_nstart (nstart),
        .o_nlen   (nlen),
        .o_npitch (npitch),
        .o_nsnd   (nsnd)
    );

    // operand for the shared multiplier, always times frames_per_beat
    always_comb begin
        unique case (r_state)
            pns_pkg::S_PAT:  mul_a = pns_pkg::BEAT_W'(plen);
            pns_pkg::S_MST:  mul_a = nstart;
            pns_pkg::S_MLEN: mul_a = nlen;
            default:         mul_a = '0;
        endcase
    end

    pns_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_fpb),
        .o_p   (prod)
    );

    assign e_frames  = {1'b0, r_s} + {1'b0, prod[pns_pkg::PROD_W-1:8]};
    assign pos_ext   = {1'b0, ppos};
    assign pos_inc   = pos_ext + (FW+1)'(1);
    assign on_hit    = !nsnd && (pos_ext >= {1'b0, r_s}) && (pos_ext < e_frames);
    assign off_hit   = nsnd && (e_frames != '0) && (pos_ext == e_frames - (FW+1)'(1));
    assign pitch_sum = {1'b0, pbase} + (pns_pkg::BASE_W+1)'(npitch);
    assign pitch_sat = (pitch_sum > (pns_pkg::BASE_W+1)'(pns_pkg::NOTE_MAX)) ?
                       pns_pkg::NOTE_MAX : pitch_sum[pns_pkg::PITCH_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_pat        = r_pat;
        n_note       = r_note;
        n_loop_end   = r_loop_end;
        n_s          = r_s;
        n_pend_valid = r_pend_valid;
        n_pend_on    = r_pend_on;
        n_pend_num   = r_pend_num;
        n_out_valid  = 1'b0;
        n_out_on     = r_out_on;
        n_out_num    = r_out_num;
        n_out_last   = r_out_last;
        upd          = '0;

        unique case (r_state)
            pns_pkg::S_IDLE: begin
                if (accept && (act == pns_pkg::ACT_TICK) && r_run) begin
                    n_pat   = '0;
                    n_state = pns_pkg::S_PAT;
                end
            end
            pns_pkg::S_PAT: begin
                n_note = '0;
                if (plen == '0) begin
                    if (r_pat == PAT_LAST) begin
                        n_state = pns_pkg::S_DONE;
                    end else begin
                        n_pat = r_pat + PW'(1);
                    end
                end else begin
                    n_state = pns_pkg::S_MST;
                end
            end
            pns_pkg::S_MST: begin
                // product of the loop length is ready only on the first note
                if (r_note == '0) begin
                    n_loop_end = prod[FW-1:0];
                end
                n_state = pns_pkg::S_MLEN;
            end
            pns_pkg::S_MLEN: begin
                n_s     = prod[pns_pkg::PROD_W-1:8];
                n_state = pns_pkg::S_EVAL;
            end
            pns_pkg::S_EVAL: begin
                upd.snd_we = on_hit || off_hit;
                upd.snd    = on_hit;
                if (on_hit || off_hit) begin
                    // hold one word back so the final one can carry last
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_on    = r_pend_on;
                        n_out_num   = r_pend_num;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_on    = on_hit;
                    n_pend_num   = pitch_sat;
                end
                if (r_note == NOTE_LAST) begin
                    n_state = pns_pkg::S_ADV;
                end else begin
                    n_note  = r_note + NW'(1);
                    n_state = pns_pkg::S_MST;
                end
            end
            pns_pkg::S_ADV: begin
                upd.pos_we = 1'b1;
                upd.pos    = (pos_inc >= {1'b0, r_loop_end}) ? '0 : pos_inc[FW-1:0];
                if (r_pat == PAT_LAST) begin
                    n_state = pns_pkg::S_DONE;
                end else begin
                    n_pat   = r_pat + PW'(1);
                    n_state = pns_pkg::S_PAT;
                end
            end
            pns_pkg::S_DONE: begin
                if (r_pend_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_on     = r_pend_on;
                    n_out_num    = r_pend_num;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
                n_state = pns_pkg::S_IDLE;
            end
            default: n_state = pns_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pns_pkg::S_IDLE;
            r_pat        <= '0;
            r_note       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fpb        <= pns_pkg::FPB_RESET;
            r_run        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pat        <= n_pat;
            r_note       <= n_note;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (pns_pkg::t_cfg_idx'(i_cfg_index))
                    pns_pkg::CFG_FPB: r_fpb <= i_cfg_data;
                    pns_pkg::CFG_RUN: r_run <= i_cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_loop_end <= n_loop_end;
        r_s        <= n_s;
        r_pend_on  <= n_pend_on;
        r_pend_num <= n_pend_num;
        r_out_on   <= n_out_on;
        r_out_num  <= n_out_num;
        r_out_last <= n_out_last;
    end

    assign o_strobe      = r_out_valid;
    assign o_is_note_on  = r_out_on;
    assign o_note_number = r_out_num;
    assign o_velocity    = r_out_on ? pns_pkg::VEL_ON : pns_pkg::VEL_OFF;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/pns_checker.sv
// pns_checker: port-level assertions for pattern_note_sequencer, bound to the top level
// depends on pns_pkg for codes and the velocity constant
`default_nettype none

module pns_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_action,
    input wire logic       o_strobe,
    input wire logic       o_is_note_on,
    input wire logic [6:0] o_velocity,
    input wire logic       o_last
);

    // reset leaves no word in flight and the block idle
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy right after reset");

    // a table write or a no-op item never produces a word
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action != pns_pkg::ACT_TICK)) |=> !o_strobe)
        else $error("word after a write item");

    // a word that is not the last of its tick leaves the scan still running
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-last word while idle");

    // velocity follows the event kind
    a_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_is_note_on ? (o_velocity == pns_pkg::VEL_ON)
                                   : (o_velocity == pns_pkg::VEL_OFF)))
        else $error("velocity does not match event kind");

endmodule

bind pattern_note_sequencer pns_checker u_pns_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .o_strobe     (o_strobe),
    .o_is_note_on (o_is_note_on),
    .o_velocity   (o_velocity),
    .o_last       (o_last)
);

`default_nettype wire
